// ----- rtl/hpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared widths, request and status codes, and the controller-to-datapath
// command and status structs for the handle pool allocator.
// ----------------------------------------------------------------------------
package hpa_pkg;

    // Default pool size.
    localparam int NUM_HANDLES_DEF = 256;

    // Fixed field widths of the request and result channels.
    localparam int KIND_W   = 2;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_RELEASE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED   = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // capture the request and start the memory reads
        logic exec;     // apply the update and load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy; // result register full and stalled downstream
    } t_sts;

endpackage

// ----- rtl/hpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_ctrl
// Two-state sequencer: takes a request, then executes it once the read data
// is back and the result register has room.
// ----------------------------------------------------------------------------
module hpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  hpa_pkg::t_sts i_sts,
    output hpa_pkg::t_cmd o_cmd
);
    import hpa_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;

    // A request is only taken while no other one is in flight.
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC) && !i_sts.out_busy;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (!i_sts.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/hpa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpa_datapath
// Free-handle queue memory, in-use map memory, pointers, fresh counter and
// the result register.
// ----------------------------------------------------------------------------
module hpa_datapath #(
    parameter int NUM_HANDLES = hpa_pkg::NUM_HANDLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpa_pkg::t_cmd                 i_cmd,
    output hpa_pkg::t_sts                 o_sts,
    input  logic [hpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [hpa_pkg::HANDLE_W-1:0]  i_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hpa_pkg::HANDLE_W-1:0]  o_granted_handle,
    output logic [hpa_pkg::STATUS_W-1:0]  o_status
);
    import hpa_pkg::*;

    localparam int HW = $clog2(NUM_HANDLES);
    localparam int CW = $clog2(NUM_HANDLES + 1);

    // Memories.
    logic [HW-1:0] r_fifo_mem [NUM_HANDLES];
    logic          r_map_mem  [NUM_HANDLES];

    // Pointers, counts and request capture.
    logic [HW-1:0]       r_head, n_head;
    logic [HW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_next_fresh, n_next_fresh;
    logic [KIND_W-1:0]   r_req_kind;
    logic [HANDLE_W-1:0] r_req_handle;
    logic [HW-1:0]       r_fifo_rd;
    logic                r_map_rd;

    // Result register.
    logic                r_out_valid;
    logic [HANDLE_W-1:0] r_granted, n_granted;
    logic [STATUS_W-1:0] r_status, n_status;

    // Memory write commands.
    logic          w_fifo_we;
    logic          w_map_we;
    logic [HW-1:0] w_map_addr;
    logic          w_map_wd;
    logic          w_in_use;

    assign o_sts.out_busy   = r_out_valid && i_out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_granted_handle = r_granted;
    assign o_status         = r_status;

    // Map entries at or above the fresh counter were never written and read as clear.
    assign w_in_use = r_map_rd && (32'(r_req_handle) < 32'(r_next_fresh));

    function automatic logic [HW-1:0] advance(input logic [HW-1:0] pos);
        return (pos == HW'(NUM_HANDLES - 1)) ? '0 : HW'(pos + 1'b1);
    endfunction

    // Request execution.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_next_fresh = r_next_fresh;
        n_granted    = '0;
        n_status     = ST_OK;
        w_fifo_we    = 1'b0;
        w_map_we     = 1'b0;
        w_map_addr   = HW'(r_req_handle);
        w_map_wd     = 1'b0;
        unique case (r_req_kind)
            KIND_ALLOC, KIND_TRY: begin
                priority if (r_count != '0) begin
                    n_head     = advance(r_head);
                    n_count    = CW'(r_count - 1'b1);
                    n_granted  = HANDLE_W'(r_fifo_rd);
                    w_map_we   = 1'b1;
                    w_map_addr = r_fifo_rd;
                    w_map_wd   = 1'b1;
                end else if (r_req_kind == KIND_TRY) begin
                    n_status = ST_NONE_FREED;
                end else if (r_next_fresh < CW'(NUM_HANDLES)) begin
                    n_next_fresh = CW'(r_next_fresh + 1'b1);
                    n_granted    = HANDLE_W'(r_next_fresh);
                    w_map_we     = 1'b1;
                    w_map_addr   = HW'(r_next_fresh);
                    w_map_wd     = 1'b1;
                end else begin
                    n_status = ST_EXHAUSTED;
                end
            end
            KIND_RELEASE: begin
                if (!w_in_use || (r_count == CW'(NUM_HANDLES))) begin
                    n_status = ST_BAD_RELEASE;
                end else begin
                    n_tail    = advance(r_tail);
                    n_count   = CW'(r_count + 1'b1);
                    w_fifo_we = 1'b1;
                    w_map_we  = 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_next_fresh <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_next_fresh <= n_next_fresh;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_kind   <= i_kind;
            r_req_handle <= i_handle;
        end
        if (i_cmd.exec) begin
            r_granted <= n_granted;
            r_status  <= n_status;
        end
    end

    // Queue memory: read at the head on accept, write at the tail on release.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_fifo_rd <= r_fifo_mem[r_head];
        end
        if (i_cmd.exec && w_fifo_we) begin
            r_fifo_mem[r_tail] <= HW'(r_req_handle);
        end
    end

    // In-use map memory: read at the request handle on accept.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_map_rd <= r_map_mem[HW'(i_handle)];
        end
        if (i_cmd.exec && w_map_we) begin
            r_map_mem[w_map_addr] <= w_map_wd;
        end
    end

endmodule

// ----- rtl/handle_pool_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_pool_allocator_unit
// Hands out object handles from a free queue or a fresh counter and takes
// them back, checking an in-use map on every release.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Fields
//  request   in         i_in_valid / o_in_stall   i_kind, i_handle
//  result    out        o_out_valid / i_out_stall o_granted_handle, o_status
//
// Each request is handled in two steps: the first captures it and reads the queue
// and map memories, the second applies the update once the registered read data is back.
// A stalled result holds the request in its execute state; a new request is
// still taken while an older result waits in the output register.
// Reset clears pointers, counters and valid flags at once; there is no
// clearing pass, since map entries at or above the fresh counter read as clear.
// ----------------------------------------------------------------------------
module handle_pool_allocator_unit #(
    parameter int NUM_HANDLES = hpa_pkg::NUM_HANDLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [hpa_pkg::KIND_W-1:0]    i_kind,
    input  logic [hpa_pkg::HANDLE_W-1:0]  i_handle,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [hpa_pkg::HANDLE_W-1:0]  o_granted_handle,
    output logic [hpa_pkg::STATUS_W-1:0]  o_status
);
    import hpa_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    hpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hpa_datapath #(
        .NUM_HANDLES (NUM_HANDLES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_kind           (i_kind),
        .i_handle         (i_handle),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_granted_handle (o_granted_handle),
        .o_status         (o_status)
    );

    // A taken request blocks the next one in the following cycle.
    a_accept_then_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request channel open right after an accept");

    // Execution never overwrites a result that is still stalled.
    a_exec_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // Every executed request shows a result in the next cycle.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_out_valid)
        else $error("executed request produced no result");

    // Failed requests never carry a handle.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_granted_handle == '0))
        else $error("failed request carries a handle");

endmodule
